/* hdl/lmgb_pkg.sv */
// ----------------------------------------------------------------------------
// lmgb_pkg
// Shared constants, types and font table for the LED matrix glyph blitter
// and scan block.
// ----------------------------------------------------------------------------
package lmgb_pkg;

  localparam int unsigned ROWS_DEF          = 8;
  localparam int unsigned BYTES_PER_ROW_DEF = 8;
  localparam int unsigned GLYPH_COUNT_DEF   = 15;

  localparam int unsigned OP_W     = 2;
  localparam int unsigned GLYPH_W  = 4;
  localparam int unsigned COL_W    = 6;
  localparam int unsigned IN_DW    = 16;
  localparam int unsigned OUT_DW   = 8;
  localparam int unsigned OUT_UW   = 5;

  localparam int unsigned FONT_ENTRIES = 15;
  localparam int unsigned FONT_ROWS    = 8;

  // command codes
  localparam logic [OP_W-1:0] OP_CLEAR = 2'd0;
  localparam logic [OP_W-1:0] OP_DRAW  = 2'd1;
  localparam logic [OP_W-1:0] OP_SCAN  = 2'd2;

  // serializer step kinds
  localparam logic [1:0] STEP_DATA  = 2'd0;
  localparam logic [1:0] STEP_ROW   = 2'd1;
  localparam logic [1:0] STEP_LATCH = 2'd2;

  typedef struct packed {
    logic [1:0] kind;
    logic [2:0] bit_idx;
    logic       first_row;
    logic       last_row;
  } scan_step_t;

  // font rows, bit 4 is the leftmost column, 0 lights the LED
  localparam logic [4:0] FONT_ROM [FONT_ENTRIES][FONT_ROWS] = '{
    '{5'h11, 5'h0E, 5'h0E, 5'h0E, 5'h0E, 5'h0E, 5'h0E, 5'h11},
    '{5'h1B, 5'h13, 5'h1B, 5'h1B, 5'h1B, 5'h1B, 5'h1B, 5'h11},
    '{5'h19, 5'h16, 5'h0E, 5'h1E, 5'h1D, 5'h1B, 5'h17, 5'h00},
    '{5'h00, 5'h1D, 5'h1B, 5'h11, 5'h1E, 5'h1E, 5'h1E, 5'h01},
    '{5'h1D, 5'h19, 5'h15, 5'h0D, 5'h00, 5'h1D, 5'h1D, 5'h1D},
    '{5'h01, 5'h0F, 5'h0F, 5'h01, 5'h1E, 5'h1E, 5'h1E, 5'h01},
    '{5'h11, 5'h0F, 5'h0F, 5'h01, 5'h0E, 5'h0E, 5'h0E, 5'h11},
    '{5'h00, 5'h1D, 5'h1B, 5'h17, 5'h0F, 5'h0F, 5'h0F, 5'h0F},
    '{5'h11, 5'h0E, 5'h0E, 5'h11, 5'h0E, 5'h0E, 5'h0E, 5'h11},
    '{5'h11, 5'h0E, 5'h0E, 5'h10, 5'h1E, 5'h1E, 5'h0E, 5'h11},
    '{5'h11, 5'h0E, 5'h0F, 5'h0F, 5'h0F, 5'h0F, 5'h0E, 5'h11},
    '{5'h18, 5'h17, 5'h0F, 5'h00, 5'h0F, 5'h0F, 5'h17, 5'h18},
    '{5'h03, 5'h0D, 5'h0E, 5'h0E, 5'h0E, 5'h0E, 5'h0D, 5'h01},
    '{5'h00, 5'h1B, 5'h1B, 5'h1B, 5'h1B, 5'h1B, 5'h1B, 5'h00},
    '{5'h00, 5'h1B, 5'h1B, 5'h1B, 5'h1B, 5'h1B, 5'h1B, 5'h1B}
  };

  function automatic logic [4:0] font_row(input logic [GLYPH_W-1:0] g,
                                          input logic [2:0] r);
    logic [4:0] bits;
    bits = 5'h1F;
    if (int'(g) < FONT_ENTRIES) begin
      bits = FONT_ROM[g][r];
    end
    return bits;
  endfunction

endpackage

/* hdl/lmgb_store.sv */
// ----------------------------------------------------------------------------
// lmgb_store
// Frame store: one write port, one read port with registered data.
// ----------------------------------------------------------------------------
module lmgb_store #(
  parameter int unsigned DEPTH = 64,
  parameter int unsigned AW    = 6
) (
  input  logic          clk_i,
  input  logic          we_i,
  input  logic [AW-1:0] waddr_i,
  input  logic [7:0]    wdata_i,
  input  logic          re_i,
  input  logic [AW-1:0] raddr_i,
  output logic [7:0]    rdata_o
);

  logic [7:0] mem_q [DEPTH];
  logic [7:0] rdata_q;

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
  end

  always_ff @(posedge clk_i) begin
    if (re_i) begin
      rdata_q <= mem_q[raddr_i];
    end
  end

  assign rdata_o = rdata_q;

endmodule

/* hdl/lmgb_blit.sv */
// ----------------------------------------------------------------------------
// lmgb_blit
// Shift-and-merge unit: places one 5-bit glyph row at a bit offset and merges
// the covered bits into one byte of the store.
// ----------------------------------------------------------------------------
module lmgb_blit (
  input  logic [4:0] bits_i,
  input  logic [2:0] shift_i,
  input  logic       half_i,     // 0: left byte, 1: right neighbor
  input  logic [7:0] old_i,
  output logic [7:0] new_o
);

  logic [15:0] pat;
  logic [15:0] msk;
  logic [7:0]  pat_b;
  logic [7:0]  msk_b;

  always_comb begin
    pat   = {bits_i, 11'd0} >> shift_i;
    msk   = {5'h1F, 11'd0} >> shift_i;
    pat_b = half_i ? pat[7:0] : pat[15:8];
    msk_b = half_i ? msk[7:0] : msk[15:8];
    new_o = (old_i & ~msk_b) | (pat_b & msk_b);
  end

endmodule

/* hdl/lmgb_scan.sv */
// ----------------------------------------------------------------------------
// lmgb_scan
// Serializer position: row and in-row step counters, decoded into the step
// kind and the store address of the byte being shifted.
// ----------------------------------------------------------------------------
module lmgb_scan #(
  parameter int unsigned ROWS          = 8,
  parameter int unsigned BYTES_PER_ROW = 8,
  parameter int unsigned AW            = 6
) (
  input  logic                  clk_i,
  input  logic                  rst_ni,
  input  logic                  adv_i,
  output lmgb_pkg::scan_step_t  step_o,
  output logic [AW-1:0]         addr_o
);
  import lmgb_pkg::*;

  localparam int unsigned DataSteps = BYTES_PER_ROW * 8;
  localparam int unsigned RW = (ROWS > 1) ? $clog2(ROWS) : 1;
  localparam int unsigned OW = $clog2(DataSteps + 2);

  logic [RW-1:0] row_q, row_d;
  logic [OW-1:0] off_q, off_d;
  logic [5:0]    byte_idx;
  logic [10:0]   addr_w;

  always_comb begin
    byte_idx = 6'(BYTES_PER_ROW - 1) - 6'(off_q >> 3);
    addr_w   = 11'(row_q) * 11'(BYTES_PER_ROW) + 11'(byte_idx);
    addr_o   = addr_w[AW-1:0];

    step_o.bit_idx   = off_q[2:0];
    step_o.first_row = (row_q == '0);
    step_o.last_row  = (row_q == RW'(ROWS - 1));
    if (off_q == OW'(DataSteps)) begin
      step_o.kind = STEP_ROW;
    end else if (off_q == OW'(DataSteps + 1)) begin
      step_o.kind = STEP_LATCH;
    end else begin
      step_o.kind = STEP_DATA;
    end

    row_d = row_q;
    off_d = off_q;
    if (adv_i) begin
      if (off_q == OW'(DataSteps + 1)) begin
        off_d = '0;
        row_d = (row_q == RW'(ROWS - 1)) ? '0 : row_q + RW'(1);
      end else begin
        off_d = off_q + OW'(1);
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      row_q <= '0;
      off_q <= '0;
    end else begin
      row_q <= row_d;
      off_q <= off_d;
    end
  end

endmodule

/* hdl/led_matrix_glyph_blit_and_scan.sv */
// ----------------------------------------------------------------------------
// led_matrix_glyph_blit_and_scan
// Active-low LED frame store with glyph draw, clear and shift-register scan.
// ----------------------------------------------------------------------------
// One request is taken at a time and each gives one result. A scan tick reads
// the store as the request is taken, then loads the result. A draw uses the
// shared shift-and-merge unit, which rewrites up to two bytes per glyph row,
// reading one byte while writing the previous one through the single store
// port pair. A clear writes all ROWS*BYTES_PER_ROW store bytes, one a cycle,
// then gives its result. After reset the same fill pass runs before the first
// request is taken. Results wait in an output register, and the next request
// is taken while one is still pending there.
module led_matrix_glyph_blit_and_scan #(
  parameter int unsigned ROWS          = lmgb_pkg::ROWS_DEF,
  parameter int unsigned BYTES_PER_ROW = lmgb_pkg::BYTES_PER_ROW_DEF,
  parameter int unsigned GLYPH_COUNT   = lmgb_pkg::GLYPH_COUNT_DEF
) (
  input  logic                        clk_i,
  input  logic                        rst_ni,
  input  logic                        s_axis_tvalid,
  output logic                        s_axis_tready,
  input  logic [lmgb_pkg::IN_DW-1:0]  s_axis_tdata,  // glyph[3:0], column[9:4]
  input  logic [lmgb_pkg::OP_W-1:0]   s_axis_tuser,  // op[1:0]
  output logic                        m_axis_tvalid,
  input  logic                        m_axis_tready,
  output logic [lmgb_pkg::OUT_DW-1:0] m_axis_tdata,  // serial_data[0], row_data[1]
  output logic [lmgb_pkg::OUT_UW-1:0] m_axis_tuser   // data_shift[0], row_shift[1],
                                                     // latch[2], frame_end[3],
                                                     // bad_glyph[4]
);
  import lmgb_pkg::*;

  localparam int unsigned Depth     = ROWS * BYTES_PER_ROW;
  localparam int unsigned AW        = (Depth > 1) ? $clog2(Depth) : 1;
  localparam int unsigned GlyphRows = (ROWS < FONT_ROWS) ? ROWS : FONT_ROWS;
  localparam int unsigned DrawSteps = 2 * GlyphRows;

  localparam logic [1:0] ST_FILL = 2'd0;
  localparam logic [1:0] ST_IDLE = 2'd1;
  localparam logic [1:0] ST_DRAW = 2'd2;
  localparam logic [1:0] ST_EMIT = 2'd3;

  logic [1:0]          state_q, state_d;
  logic [AW-1:0]       fill_q, fill_d;
  logic                emit_after_q, emit_after_d;
  logic [4:0]          k_q, k_d;
  logic [GLYPH_W-1:0]  glyph_q, glyph_d;
  logic [COL_W-1:0]    col_q, col_d;
  logic                pend_scan_q, pend_scan_d;
  logic                pend_bad_q, pend_bad_d;
  scan_step_t          pend_step_q, pend_step_d;

  logic                m_valid_q, m_valid_d;
  logic [1:0]          m_data_q, m_data_d;
  logic [OUT_UW-1:0]   m_user_q, m_user_d;

  logic                s_fire;
  logic [OP_W-1:0]     in_op;
  logic [GLYPH_W-1:0]  in_glyph;
  logic [COL_W-1:0]    in_col;
  logic                bad;

  scan_step_t          scan_step;
  logic [AW-1:0]       scan_addr;
  logic                scan_adv;

  logic                st_we;
  logic [AW-1:0]       st_waddr;
  logic [7:0]          st_wdata;
  logic                st_re;
  logic [AW-1:0]       st_raddr;
  logic [7:0]          st_rdata;

  logic [4:0]          wk;
  logic [3:0]          rd_bidx, wr_bidx;
  logic [10:0]         rd_addr_w, wr_addr_w;
  logic                wr_in_range;
  logic [7:0]          blit_out;
  logic                out_load;
  logic                ser_bit;

  assign in_op    = s_axis_tuser;
  assign in_glyph = s_axis_tdata[GLYPH_W-1:0];
  assign in_col   = s_axis_tdata[GLYPH_W+COL_W-1:GLYPH_W];
  assign s_axis_tready = (state_q == ST_IDLE);
  assign s_fire   = s_axis_tvalid && s_axis_tready;
  assign bad      = (7'(in_glyph) >= 7'(GLYPH_COUNT)) ||
                    (7'(in_glyph) >= 7'(FONT_ENTRIES));
  assign scan_adv = s_fire && (in_op == OP_SCAN);

  lmgb_scan #(
    .ROWS          (ROWS),
    .BYTES_PER_ROW (BYTES_PER_ROW),
    .AW            (AW)
  ) u_scan (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .adv_i  (scan_adv),
    .step_o (scan_step),
    .addr_o (scan_addr)
  );

  // draw addressing: step k reads, step k-1 writes; bit 0 picks the byte half
  always_comb begin
    wk          = k_q - 5'd1;
    rd_bidx     = {1'b0, col_q[5:3]} + {3'd0, k_q[0]};
    wr_bidx     = {1'b0, col_q[5:3]} + {3'd0, wk[0]};
    rd_addr_w   = 11'(k_q[4:1]) * 11'(BYTES_PER_ROW) + 11'(rd_bidx);
    wr_addr_w   = 11'(wk[4:1]) * 11'(BYTES_PER_ROW) + 11'(wr_bidx);
    wr_in_range = (6'(wr_bidx) < 6'(BYTES_PER_ROW));
  end

  lmgb_blit u_blit (
    .bits_i  (font_row(glyph_q, wk[3:1])),
    .shift_i (col_q[2:0]),
    .half_i  (wk[0]),
    .old_i   (st_rdata),
    .new_o   (blit_out)
  );

  always_comb begin
    st_we    = 1'b0;
    st_waddr = fill_q;
    st_wdata = 8'hFF;
    st_re    = 1'b0;
    st_raddr = scan_addr;
    unique case (state_q)
      ST_FILL: begin
        st_we = 1'b1;
      end
      ST_IDLE: begin
        st_re = 1'b1;
      end
      ST_DRAW: begin
        st_re    = (k_q != 5'(DrawSteps));
        st_raddr = rd_addr_w[AW-1:0];
        st_we    = (k_q != 5'd0) && wr_in_range;
        st_waddr = wr_addr_w[AW-1:0];
        st_wdata = blit_out;
      end
      default: begin
      end
    endcase
  end

  lmgb_store #(
    .DEPTH (Depth),
    .AW    (AW)
  ) u_store (
    .clk_i   (clk_i),
    .we_i    (st_we),
    .waddr_i (st_waddr),
    .wdata_i (st_wdata),
    .re_i    (st_re),
    .raddr_i (st_raddr),
    .rdata_o (st_rdata)
  );

  assign ser_bit  = st_rdata[pend_step_q.bit_idx];
  assign out_load = (state_q == ST_EMIT) && (!m_valid_q || m_axis_tready);

  always_comb begin
    state_d      = state_q;
    fill_d       = fill_q;
    emit_after_d = emit_after_q;
    k_d          = k_q;
    glyph_d      = glyph_q;
    col_d        = col_q;
    pend_scan_d  = pend_scan_q;
    pend_bad_d   = pend_bad_q;
    pend_step_d  = pend_step_q;

    unique case (state_q)
      ST_FILL: begin
        fill_d = fill_q + AW'(1);
        if (fill_q == AW'(Depth - 1)) begin
          fill_d  = '0;
          state_d = emit_after_q ? ST_EMIT : ST_IDLE;
        end
      end
      ST_IDLE: begin
        if (s_fire) begin
          pend_scan_d = 1'b0;
          pend_bad_d  = 1'b0;
          pend_step_d = scan_step;
          state_d     = ST_EMIT;
          unique case (in_op)
            OP_CLEAR: begin
              fill_d       = '0;
              emit_after_d = 1'b1;
              state_d      = ST_FILL;
            end
            OP_DRAW: begin
              if (bad) begin
                pend_bad_d = 1'b1;
              end else begin
                glyph_d = in_glyph;
                col_d   = in_col;
                k_d     = '0;
                state_d = ST_DRAW;
              end
            end
            OP_SCAN: begin
              pend_scan_d = 1'b1;
            end
            default: begin
            end
          endcase
        end
      end
      ST_DRAW: begin
        k_d = k_q + 5'd1;
        if (k_q == 5'(DrawSteps)) begin
          state_d = ST_EMIT;
        end
      end
      ST_EMIT: begin
        if (out_load) begin
          state_d = ST_IDLE;
        end
      end
      default: begin
        state_d = ST_IDLE;
      end
    endcase
  end

  always_comb begin
    m_valid_d = m_valid_q && !m_axis_tready;
    m_data_d  = m_data_q;
    m_user_d  = m_user_q;
    if (out_load) begin
      m_valid_d = 1'b1;
      m_data_d  = {pend_scan_q && (pend_step_q.kind == STEP_ROW) && pend_step_q.first_row,
                   pend_scan_q && (pend_step_q.kind == STEP_DATA) && ser_bit};
      m_user_d  = {pend_bad_q,
                   pend_scan_q && (pend_step_q.kind == STEP_LATCH) && pend_step_q.last_row,
                   pend_scan_q && (pend_step_q.kind == STEP_LATCH),
                   pend_scan_q && (pend_step_q.kind == STEP_ROW),
                   pend_scan_q && (pend_step_q.kind == STEP_DATA)};
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q      <= ST_FILL;
      fill_q       <= '0;
      emit_after_q <= 1'b0;
      k_q          <= '0;
      pend_scan_q  <= 1'b0;
      pend_bad_q   <= 1'b0;
      m_valid_q    <= 1'b0;
    end else begin
      state_q      <= state_d;
      fill_q       <= fill_d;
      emit_after_q <= emit_after_d;
      k_q          <= k_d;
      pend_scan_q  <= pend_scan_d;
      pend_bad_q   <= pend_bad_d;
      m_valid_q    <= m_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    glyph_q     <= glyph_d;
    col_q       <= col_d;
    pend_step_q <= pend_step_d;
    m_data_q    <= m_data_d;
    m_user_q    <= m_user_d;
  end

  assign m_axis_tvalid = m_valid_q;
  assign m_axis_tdata  = {6'd0, m_data_q};
  assign m_axis_tuser  = m_user_q;

`ifndef SYNTHESIS
  a_we_only_fill_or_draw: assert property (@(posedge clk_i) disable iff (!rst_ni)
    st_we |-> (state_q == ST_FILL) || (state_q == ST_DRAW))
    else $error("store written outside fill or draw");

  a_one_pulse_kind: assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid |-> $onehot0(m_axis_tuser[2:0]))
    else $error("more than one pulse kind in one result");

  a_frame_end_latch: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (m_axis_tvalid && m_axis_tuser[3]) |-> m_axis_tuser[2])
    else $error("frame end without latch");

  a_scan_to_emit: assert property (@(posedge clk_i) disable iff (!rst_ni)
    scan_adv |=> (state_q == ST_EMIT) && pend_scan_q)
    else $error("scan request did not go straight to result");

  a_bad_no_draw: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (s_fire && (in_op == OP_DRAW) && bad) |=> (state_q == ST_EMIT) && pend_bad_q)
    else $error("bad glyph request entered draw");
`endif

endmodule
